>>> design/ffreq_pkg.sv
// Shared types and constants for the feature frequency table.
`timescale 1ns / 1ps
`default_nettype none

package ffreq_pkg;

   // Field widths of a request and a response.
   localparam int FEAT_W   = 16;
   localparam int DOM_W    = 4;
   localparam int FREQ_W   = 8;
   localparam int CNT_W    = 17;
   localparam int UNSEEN_W = 16;
   localparam int WEIGHT_W = 64;
   localparam int FW_W     = 9;
   localparam int PROD_W   = CNT_W + FW_W;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 88;

   // Saturation limits, reset values and the weight unit.
   localparam logic [CNT_W-1:0]    COUNT_MAX  = '1;
   localparam logic [UNSEEN_W-1:0] UNSEEN_MAX = '1;
   localparam logic [FREQ_W-1:0]   THRESHOLD_RESET = 8'd100;
   localparam logic [CNT_W-1:0]    WEIGHT_UNIT = 17'd256;

   // Request kinds carried on tuser.
   localparam logic OP_QUERY  = 1'b0;
   localparam logic OP_RECORD = 1'b1;

   // Index of the last divider step.
   localparam logic [4:0] DIV_LAST = 5'(CNT_W - 1);

   // Divider operand selection.
   localparam logic DIV_SEL_RATIO = 1'b0;
   localparam logic DIV_SEL_FREQ  = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clr_step;
      logic capture;
      logic mem_rd;
      logic exec;
      logic div_start;
      logic div_sel;
      logic take_ratio;
      logic mul;
      logic load;
   } ffreq_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic query_ok;
      logic div_done;
      logic out_free;
   } ffreq_status_type;

endpackage

`default_nettype wire

>>> design/ffreq_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module ffreq_div
   import ffreq_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [CNT_W-1:0] dividend,
   input  wire logic [CNT_W-1:0] divisor,
   output logic      [CNT_W-1:0] quotient,
   output logic                  done
);

   logic             busy_ff, done_ff;
   logic [4:0]       cnt_ff;
   logic [CNT_W-1:0] rem_ff, quo_ff, dvs_ff;
   logic [CNT_W:0]   trial, diff;
   logic             fits;

   // One trial subtraction per step.
   always_comb begin
      trial = {rem_ff, quo_ff[CNT_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = trial >= {1'b0, dvs_ff};
   end

   // Step control.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == DIV_LAST);
         if (busy_ff && (cnt_ff == DIV_LAST)) begin
            busy_ff <= 1'b0;
         end
         if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
         end
      end
   end

   // Remainder and quotient shift registers.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         quo_ff <= {quo_ff[CNT_W-2:0], fits};
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

>>> design/ffreq_ctrl.sv
// Controller state machine that sequences each request through the datapath.
`timescale 1ns / 1ps
`default_nettype none

module ffreq_ctrl
   import ffreq_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire ffreq_status_type status,
   output ffreq_cmd_type         cmd
);

   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_READ  = 8'b0000_0100,
      S_EXEC  = 8'b0000_1000,
      S_DIVA  = 8'b0001_0000,
      S_DIVB  = 8'b0010_0000,
      S_MUL   = 8'b0100_0000,
      S_OUT   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_READ;
            end
         end
         S_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (status.query_ok) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_SEL_RATIO;
               state_in      = S_DIVA;
            end else begin
               state_in = S_OUT;
            end
         end
         S_DIVA: begin
            if (status.div_done) begin
               cmd.take_ratio = 1'b1;
               cmd.div_start  = 1'b1;
               cmd.div_sel    = DIV_SEL_FREQ;
               state_in       = S_DIVB;
            end
         end
         S_DIVB: begin
            if (status.div_done) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

endmodule

`default_nettype wire

>>> design/ffreq_dp.sv
// Datapath: frequency and domain memories, counters, divider and output register.
`timescale 1ns / 1ps
`default_nettype none

module ffreq_dp
   import ffreq_pkg::*;
#(
   parameter int TABLE_ENTRIES = 65536,
   parameter int NUM_DOMAINS   = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ffreq_cmd_type         cmd,
   output ffreq_status_type           status,
   input  wire logic                  req_op,
   input  wire logic [FEAT_W-1:0]     req_feature,
   input  wire logic [DOM_W-1:0]      req_domain,
   input  wire logic                  req_last,
   input  wire logic                  csr_wr_en,
   input  wire logic [FREQ_W-1:0]     csr_wr_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [RSP_DATA_W-1:0]      rsp_data,
   output logic                       rsp_last
);

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int DW = (NUM_DOMAINS > 1) ? $clog2(NUM_DOMAINS) : 1;

   // Memories.
   logic [FREQ_W-1:0] freq_mem [TABLE_ENTRIES];
   logic [CNT_W-1:0]  dom_mem  [NUM_DOMAINS];

   logic [FREQ_W-1:0]   thresh_ff;
   logic [AW-1:0]       clr_ff;
   logic                op_ff, last_ff, dom_ok_ff;
   logic [AW-1:0]       slot_ff;
   logic [DW-1:0]       didx_ff;
   logic [FREQ_W-1:0]   freq_ff;
   logic [CNT_W-1:0]    dcnt_ff, distinct_ff, ratio_ff;
   logic                unseen_ff, keep_ff, err_ff, add_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [UNSEEN_W-1:0] run_unseen_ff, run_unseen_in;
   logic [WEIGHT_W-1:0] run_weight_ff, run_weight_in;
   logic                rsp_valid_ff, rsp_last_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [AW+FEAT_W-1:0] feat_ext;
   logic [DW+DOM_W-1:0]  dom_ext;
   logic [CNT_W-1:0]     dcnt_eff, div_a, div_b, quo;
   logic                 unseen_now, keep_now, err_now, div_done;

   assign feat_ext = {{AW{1'b0}}, req_feature};
   assign dom_ext  = {{DW{1'b0}}, req_domain};

   // Threshold register.
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESHOLD_RESET;
      end else if (csr_wr_en) begin
         thresh_ff <= csr_wr_data;
      end
   end

   // Clearing pass address after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end
   assign status.clear_last = (clr_ff == AW'(TABLE_ENTRIES - 1));

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_op;
         last_ff   <= req_last;
         slot_ff   <= feat_ext[AW-1:0];
         didx_ff   <= dom_ext[DW-1:0];
         dom_ok_ff <= (32'(req_domain) < NUM_DOMAINS);
      end
   end

   // Decisions from the entries read.
   always_comb begin
      dcnt_eff   = dom_ok_ff ? dcnt_ff : '0;
      unseen_now = (freq_ff == '0);
      keep_now   = (freq_ff < thresh_ff);
      err_now    = unseen_now || (dcnt_eff == '0);
   end
   assign status.query_ok = (op_ff == OP_QUERY) && !err_now;

   // Frequency table port.
   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         freq_mem[clr_ff] <= '0;
      end else if (cmd.exec && (op_ff == OP_RECORD) && keep_now) begin
         freq_mem[slot_ff] <= freq_ff + FREQ_W'(1);
      end
      if (cmd.mem_rd) begin
         freq_ff <= freq_mem[slot_ff];
      end
   end

   // Domain count port.
   always_ff @(posedge clock) begin
      if (cmd.clr_step && (32'(clr_ff) < NUM_DOMAINS)) begin
         dom_mem[clr_ff[DW-1:0]] <= '0;
      end else if (cmd.exec && (op_ff == OP_RECORD) && unseen_now && dom_ok_ff) begin
         dom_mem[didx_ff] <= (dcnt_ff == COUNT_MAX) ? dcnt_ff : dcnt_ff + CNT_W'(1);
      end
      if (cmd.mem_rd) begin
         dcnt_ff <= dom_mem[didx_ff];
      end
   end

   // Distinct feature total.
   always_ff @(posedge clock) begin
      if (reset) begin
         distinct_ff <= '0;
      end else if (cmd.exec && (op_ff == OP_RECORD) && unseen_now &&
                   (distinct_ff != COUNT_MAX)) begin
         distinct_ff <= distinct_ff + CNT_W'(1);
      end
   end

   // Per-request flags.
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         unseen_ff <= unseen_now;
         keep_ff   <= keep_now;
         err_ff    <= (op_ff == OP_QUERY) && err_now;
         add_ff    <= status.query_ok;
      end
   end

   // Shared divider: first the domain ratio, then the frequency weight.
   assign div_a = (cmd.div_sel == DIV_SEL_FREQ) ? WEIGHT_UNIT : distinct_ff;
   assign div_b = (cmd.div_sel == DIV_SEL_FREQ) ? CNT_W'(freq_ff) : dcnt_eff;

   ffreq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .quotient (quo),
      .done     (div_done)
   );
   assign status.div_done = div_done;

   always_ff @(posedge clock) begin
      if (cmd.take_ratio) begin
         ratio_ff <= quo;
      end
      if (cmd.mul) begin
         prod_ff <= ratio_ff * quo[FW_W-1:0];
      end
   end

   // Running sums after this request.
   always_comb begin
      run_unseen_in = run_unseen_ff;
      if ((op_ff == OP_QUERY) && unseen_ff && (run_unseen_ff != UNSEEN_MAX)) begin
         run_unseen_in = run_unseen_ff + UNSEEN_W'(1);
      end
      run_weight_in = add_ff ? run_weight_ff + WEIGHT_W'(prod_ff) : run_weight_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_unseen_ff <= '0;
         run_weight_ff <= '0;
      end else if (cmd.load) begin
         run_unseen_ff <= last_ff ? '0 : run_unseen_in;
         run_weight_ff <= last_ff ? '0 : run_weight_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_data_ff <= {5'd0, err_ff, run_weight_in, run_unseen_in, keep_ff, unseen_ff};
         rsp_last_ff <= last_ff;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

`default_nettype wire

>>> design/feature_frequency_table.sv
// Top level of the feature frequency table.
//
// Requests arrive on the req_ stream: tuser is the kind (0 query, 1 record),
// tdata holds the feature index and the domain, tlast marks the last feature
// of a vector. Each request gives one response on the rsp_ stream with the
// unseen and keep flags, the running unseen count, the running weight and
// the error flag; rsp_tlast echoes the request's tlast.
// The threshold register is written through csr_wr_en and csr_wr_data.
// One request is worked on at a time. A record goes from accept through a
// memory read and an execute step to the response. A query also runs the
// shared divider for the domain ratio and then for the frequency weight, one
// bit per cycle, each ending with a done report, and then forms the product.
// A query that finds a zero frequency or a zero domain count skips the
// divider and goes straight to the response.
// After reset the frequency table is cleared one entry per cycle
// (TABLE_ENTRIES must be a power of two); req_tready stays low until the
// clearing is done. A finished response waits in the output register
// while the next request is accepted; a stalled receiver holds that request
// back only when its own response is ready.
`timescale 1ns / 1ps
`default_nettype none

module feature_frequency_table
   import ffreq_pkg::*;
#(
   parameter int TABLE_ENTRIES = 65536,
   parameter int NUM_DOMAINS   = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // feature [15:0], domain [19:16], zero [23:20]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // op
   input  wire logic                  req_tuser,
   input  wire logic                  req_tlast,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // unseen [0], keep [1], unseen_total [17:2], weight_total [81:18],
   // error [82], zero [87:83]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast,
   input  wire logic                  csr_wr_en,
   input  wire logic [FREQ_W-1:0]     csr_wr_data
);

   ffreq_cmd_type    cmd;
   ffreq_status_type status;

   ffreq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ffreq_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .NUM_DOMAINS   (NUM_DOMAINS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_op      (req_tuser),
      .req_feature (req_tdata[FEAT_W-1:0]),
      .req_domain  (req_tdata[FEAT_W+DOM_W-1:FEAT_W]),
      .req_last    (req_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_data    (rsp_tdata),
      .rsp_last    (rsp_tlast)
   );

endmodule

`default_nettype wire

>>> design/ffreq_checker.sv
// Port checker for the feature frequency table and its bind.
`timescale 1ns / 1ps
`default_nettype none

module ffreq_checker
   import ffreq_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tlast
);

   // Reset empties the output and starts the clearing pass.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("outputs active after reset");

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // Only one request is in work at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request accepted while busy");

   // No response can follow an accept in the very next cycle unless one waited.
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (!rsp_tvalid || rsp_tready) |=> !rsp_tvalid)
      else $error("response appeared too early");

endmodule

bind feature_frequency_table ffreq_checker u_ffreq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
